// File: design/spai_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spai_pkg
// Shared types, register indexes and fixed-point coefficients for the stereo
// pair anaglyph and row interlace core.
// ----------------------------------------------------------------------------
package spai_pkg;

    localparam int MAX_WIDTH      = 4096;
    localparam int COEF_FRAC_BITS = 12;

    localparam int CHAN_W  = 8;
    localparam int LW_W    = 13;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W   = 13;

    // All coefficients have a magnitude below 2.0.
    localparam int COEF_W  = COEF_FRAC_BITS + 2;
    localparam int PROD_W  = COEF_W + CHAN_W + 1;
    localparam int SUM_W   = PROD_W + 3;

    typedef enum logic [1:0] {
        MODE_OPTIMIZED = 2'd0,
        MODE_DUBOIS    = 2'd1,
        MODE_IL_LR     = 2'd2,
        MODE_IL_RL     = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RENDER_MODE  = 2'd0,
        REG_WINDOW_Y_ODD = 2'd1,
        REG_LINE_WIDTH   = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [CHAN_W-1:0] left_red;
        logic [CHAN_W-1:0] left_green;
        logic [CHAN_W-1:0] left_blue;
        logic [CHAN_W-1:0] right_red;
        logic [CHAN_W-1:0] right_green;
        logic [CHAN_W-1:0] right_blue;
        logic              frame_end;
    } pair_t;

    // Decimal coefficient in thousandths to signed Q format, halves away from zero.
    function automatic logic signed [COEF_W-1:0] to_fixed(input int milli);
        int mag;
        int q;
        mag = (milli < 0) ? -milli : milli;
        q   = (mag * (2 ** COEF_FRAC_BITS) * 2 + 1000) / 2000;
        return (milli < 0) ? COEF_W'(-q) : COEF_W'(q);
    endfunction

    localparam logic signed [COEF_W-1:0] OPT_BLUE_COEF  = to_fixed(300);
    localparam logic signed [COEF_W-1:0] OPT_GREEN_COEF = to_fixed(700);

    // Rows red, green, blue; columns lR lG lB rR rG rB.
    localparam logic signed [COEF_W-1:0] DUBOIS_COEF [3][6] = '{
        '{to_fixed(456),  to_fixed(500),  to_fixed(176),
          to_fixed(-43),  to_fixed(-88),  to_fixed(-2)},
        '{to_fixed(-40),  to_fixed(-38),  to_fixed(-16),
          to_fixed(378),  to_fixed(734),  to_fixed(-18)},
        '{to_fixed(-15),  to_fixed(-21),  to_fixed(-5),
          to_fixed(-72),  to_fixed(-113), to_fixed(1226)}
    };

    // Negative sums give zero; otherwise truncate and saturate at full scale.
    function automatic logic [CHAN_W-1:0] clamp_sum(input logic signed [SUM_W-1:0] sum);
        logic signed [SUM_W-1:0] v;
        v = sum >>> COEF_FRAC_BITS;
        if (sum[SUM_W-1])
            return '0;
        else if (|v[SUM_W-1:CHAN_W])
            return '1;
        else
            return v[CHAN_W-1:0];
    endfunction

endpackage

// File: design/spai_pair_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spai_pair_if
// Stream channel that carries one left/right RGB pixel pair per transaction.
// ----------------------------------------------------------------------------
interface spai_pair_if
    import spai_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] left_red;
    logic [CHAN_W-1:0] left_green;
    logic [CHAN_W-1:0] left_blue;
    logic [CHAN_W-1:0] right_red;
    logic [CHAN_W-1:0] right_green;
    logic [CHAN_W-1:0] right_blue;
    logic              frame_end;

    modport source (
        output valid, left_red, left_green, left_blue,
               right_red, right_green, right_blue, frame_end,
        input  ready
    );

    modport sink (
        input  valid, left_red, left_green, left_blue,
               right_red, right_green, right_blue, frame_end,
        output ready
    );
endinterface

// File: design/spai_pixel_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spai_pixel_if
// Stream channel that carries one output RGB pixel per transaction.
// ----------------------------------------------------------------------------
interface spai_pixel_if
    import spai_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic              out_last;

    modport source (
        output valid, out_red, out_green, out_blue, out_last,
        input  ready
    );

    modport sink (
        input  valid, out_red, out_green, out_blue, out_last,
        output ready
    );
endinterface

// File: design/stereo_pair_anaglyph_interlace_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_pair_anaglyph_interlace_core
// Combines a stereo pixel pair into one pixel: optimized anaglyph, Dubois
// anaglyph, or row interlace with either side first.
//
//   channel   direction  handshake      payload
//   pair      in         valid/ready    six 8-bit channels, frame_end
//   pixel     out        valid/ready    out_red/green/blue, out_last
//   cfg       in         cfg_we         cfg_index (2b), cfg_wdata (13b)
//
// One pixel pair is accepted per clock unless an output stall backs up to the
// input. A pixel is offered on the output once its pair has passed the input
// register and the result register, which the channel arithmetic fills. The
// Dubois matrix products are the longest path. Stalls on the output back up
// through both stages; each stage refills in the cycle it empties. Reset
// empties the pipeline and counters and restores the register defaults.
// ----------------------------------------------------------------------------
module stereo_pair_anaglyph_interlace_core
    import spai_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    spai_pair_if.sink            pair,
    spai_pixel_if.source         pixel
);

    // Configuration registers.
    mode_t             render_mode_reg;
    logic              window_y_odd_reg;
    logic [LW_W-1:0]   line_width_reg;

    // Frame position.
    logic [COL_W-1:0]  col_count_reg;
    logic [COL_W-1:0]  col_count_next;
    logic              row_odd_reg;
    logic              row_odd_next;
    logic [LW_W-1:0]   eff_width;
    logic [LW_W-1:0]   col_plus;
    logic              row_wrap;

    // Pipeline.
    logic              s1_valid_reg;
    pair_t             s1_pair_reg;
    mode_t             s1_mode_reg;
    logic              s1_side_reg;
    logic              s2_valid_reg;
    logic [CHAN_W-1:0] s2_red_reg;
    logic [CHAN_W-1:0] s2_green_reg;
    logic [CHAN_W-1:0] s2_blue_reg;
    logic              s2_last_reg;

    logic              s2_load;
    logic              pair_accept;
    logic              side_next;
    logic [CHAN_W-1:0] red_next;
    logic [CHAN_W-1:0] green_next;
    logic [CHAN_W-1:0] blue_next;

    assign s2_load     = !s2_valid_reg || pixel.ready;
    assign pair.ready  = !s1_valid_reg || s2_load;
    assign pair_accept = pair.valid && pair.ready;

    // Width zero acts as one; widths above the line buffer limit are capped.
    always_comb
    begin
        if (line_width_reg == '0)
            eff_width = LW_W'(1);
        else if (line_width_reg > LW_W'(MAX_WIDTH))
            eff_width = LW_W'(MAX_WIDTH);
        else
            eff_width = line_width_reg;

        col_plus = LW_W'(col_count_reg) + LW_W'(1);
        row_wrap = (col_plus >= eff_width);

        if (pair.frame_end)
        begin
            col_count_next = '0;
            row_odd_next   = 1'b0;
        end
        else if (row_wrap)
        begin
            col_count_next = '0;
            row_odd_next   = !row_odd_reg;
        end
        else
        begin
            col_count_next = col_plus[COL_W-1:0];
            row_odd_next   = row_odd_reg;
        end

        // High selects the right image for the current row.
        side_next = window_y_odd_reg ^ (render_mode_reg == MODE_IL_RL) ^ row_odd_reg;
    end

    // Channel arithmetic on the registered pair.
    always_comb
    begin
        logic signed [CHAN_W:0]  ch [6];
        logic signed [SUM_W-1:0] sum [3];
        logic signed [SUM_W-1:0] opt_sum;

        ch[0] = signed'({1'b0, s1_pair_reg.left_red});
        ch[1] = signed'({1'b0, s1_pair_reg.left_green});
        ch[2] = signed'({1'b0, s1_pair_reg.left_blue});
        ch[3] = signed'({1'b0, s1_pair_reg.right_red});
        ch[4] = signed'({1'b0, s1_pair_reg.right_green});
        ch[5] = signed'({1'b0, s1_pair_reg.right_blue});

        for (int k = 0; k < 3; k++)
        begin
            sum[k] = '0;
            for (int i = 0; i < 6; i++)
                sum[k] = sum[k] + SUM_W'(PROD_W'(ch[i] * DUBOIS_COEF[k][i]));
        end

        opt_sum = SUM_W'(PROD_W'(ch[2] * OPT_BLUE_COEF))
                + SUM_W'(PROD_W'(ch[1] * OPT_GREEN_COEF));

        unique case (s1_mode_reg)
            MODE_OPTIMIZED:
            begin
                red_next   = clamp_sum(opt_sum);
                green_next = s1_pair_reg.right_green;
                blue_next  = s1_pair_reg.right_blue;
            end
            MODE_DUBOIS:
            begin
                red_next   = clamp_sum(sum[0]);
                green_next = clamp_sum(sum[1]);
                blue_next  = clamp_sum(sum[2]);
            end
            MODE_IL_LR, MODE_IL_RL:
            begin
                red_next   = s1_side_reg ? s1_pair_reg.right_red   : s1_pair_reg.left_red;
                green_next = s1_side_reg ? s1_pair_reg.right_green : s1_pair_reg.left_green;
                blue_next  = s1_side_reg ? s1_pair_reg.right_blue  : s1_pair_reg.left_blue;
            end
            default:
            begin
                red_next   = '0;
                green_next = '0;
                blue_next  = '0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            render_mode_reg  <= MODE_OPTIMIZED;
            window_y_odd_reg <= 1'b0;
            line_width_reg   <= LW_W'(640);
            col_count_reg    <= '0;
            row_odd_reg      <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (reg_index_t'(cfg_index))
                    REG_RENDER_MODE:  render_mode_reg  <= mode_t'(cfg_wdata[1:0]);
                    REG_WINDOW_Y_ODD: window_y_odd_reg <= cfg_wdata[0];
                    REG_LINE_WIDTH:   line_width_reg   <= cfg_wdata[LW_W-1:0];
                    default:          ;
                endcase
            end

            if (pair_accept)
            begin
                col_count_reg <= col_count_next;
                row_odd_reg   <= row_odd_next;
            end

            if (pair.ready)
                s1_valid_reg <= pair.valid;
            if (s2_load)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (pair_accept)
        begin
            s1_pair_reg.left_red    <= pair.left_red;
            s1_pair_reg.left_green  <= pair.left_green;
            s1_pair_reg.left_blue   <= pair.left_blue;
            s1_pair_reg.right_red   <= pair.right_red;
            s1_pair_reg.right_green <= pair.right_green;
            s1_pair_reg.right_blue  <= pair.right_blue;
            s1_pair_reg.frame_end   <= pair.frame_end;
            s1_mode_reg             <= render_mode_reg;
            s1_side_reg             <= side_next;
        end
        if (s2_load && s1_valid_reg)
        begin
            s2_red_reg   <= red_next;
            s2_green_reg <= green_next;
            s2_blue_reg  <= blue_next;
            s2_last_reg  <= s1_pair_reg.frame_end;
        end
    end

    assign pixel.valid     = s2_valid_reg;
    assign pixel.out_red   = s2_red_reg;
    assign pixel.out_green = s2_green_reg;
    assign pixel.out_blue  = s2_blue_reg;
    assign pixel.out_last  = s2_last_reg;

    // A frame end always returns the position to the top left corner.
    assert property (@(posedge clk) disable iff (!rst_n)
        pair_accept && pair.frame_end |=> (col_count_reg == '0) && !row_odd_reg)
        else $error("position not cleared after frame end");

    // Reaching the row width wraps the column and flips the row parity.
    assert property (@(posedge clk) disable iff (!rst_n)
        pair_accept && !pair.frame_end && row_wrap
        |=> (col_count_reg == '0) && (row_odd_reg != $past(row_odd_reg)))
        else $error("row wrap missed");

    // An item held in the input stage is not dropped while the output stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_load |=> s1_valid_reg)
        else $error("input stage lost an item");

    // Interlace output takes its red and blue channels from one side of the pair.
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_load && s1_valid_reg && (s1_mode_reg == MODE_IL_LR || s1_mode_reg == MODE_IL_RL)
        |=> (pixel.out_red == $past(s1_pair_reg.left_red)
             && pixel.out_blue == $past(s1_pair_reg.left_blue))
         || (pixel.out_red == $past(s1_pair_reg.right_red)
             && pixel.out_blue == $past(s1_pair_reg.right_blue)))
        else $error("interlace output mixes sides");

endmodule

// File: bench/spai_pixel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spai_pixel_checker
// Watches the pair, pixel and register channels of the stereo combiner. It
// keeps its own copy of the mode, window parity, line width and position
// counters, works out the pixel that each accepted pair must give, and
// compares every accepted output pixel with the oldest pixel still owed.
// ----------------------------------------------------------------------------
module spai_pixel_checker
    import spai_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    spai_pair_if                 pair_mon,
    spai_pixel_if                pixel_mon,
    output int                   mismatch_count,
    output int                   pending_count
);

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              last;
    } pixel_t;

    mode_t          mode_q;
    logic           win_odd_q;
    logic [LW_W-1:0] width_q;
    int             col_pos;
    logic           row_odd;
    pixel_t         owed_pixels[$];
    pixel_t         seen_px;
    pixel_t         owed_px;
    pair_t          pair_in;

    // Coefficient given in thousandths, as signed fixed point, halves away from zero.
    function automatic int milli_to_fixed(input int milli);
        int mag;
        int q;
        mag = (milli < 0) ? -milli : milli;
        q   = (mag * (1 << (COEF_FRAC_BITS + 1)) + 1000) / 2000;
        return (milli < 0) ? -q : q;
    endfunction

    // Rows are red, green, blue; columns are lR lG lB rR rG rB.
    function automatic int dubois_weight(input int row, input int col);
        int milli;
        case (row * 6 + col)
            0:       milli = 456;
            1:       milli = 500;
            2:       milli = 176;
            3:       milli = -43;
            4:       milli = -88;
            5:       milli = -2;
            6:       milli = -40;
            7:       milli = -38;
            8:       milli = -16;
            9:       milli = 378;
            10:      milli = 734;
            11:      milli = -18;
            12:      milli = -15;
            13:      milli = -21;
            14:      milli = -5;
            15:      milli = -72;
            16:      milli = -113;
            default: milli = 1226;
        endcase
        return milli_to_fixed(milli);
    endfunction

    function automatic logic [CHAN_W-1:0] saturate_channel(input longint sum);
        longint v;
        if (sum < 0)
            return '0;
        v = sum >>> COEF_FRAC_BITS;
        return (v > 255) ? 8'd255 : v[CHAN_W-1:0];
    endfunction

    function automatic int row_length(input logic [LW_W-1:0] width);
        if (width == 0)
            return 1;
        if (width > MAX_WIDTH)
            return MAX_WIDTH;
        return int'(width);
    endfunction

    function automatic pixel_t predict_pixel(input pair_t p, input mode_t mode,
                                             input logic win_odd, input logic odd_row);
        int           ch[6];
        longint       sum;
        logic [7:0]   res[3];
        logic         take_right;
        pixel_t       px;
        int           k;
        int           c;
        ch[0] = int'(p.left_red);
        ch[1] = int'(p.left_green);
        ch[2] = int'(p.left_blue);
        ch[3] = int'(p.right_red);
        ch[4] = int'(p.right_green);
        ch[5] = int'(p.right_blue);
        px      = '0;
        px.last = p.frame_end;
        case (mode)
            MODE_OPTIMIZED:
            begin
                sum = longint'(ch[2]) * milli_to_fixed(300)
                    + longint'(ch[1]) * milli_to_fixed(700);
                px.red   = saturate_channel(sum);
                px.green = p.right_green;
                px.blue  = p.right_blue;
            end
            MODE_DUBOIS:
            begin
                for (k = 0; k < 3; k++)
                begin
                    sum = 0;
                    for (c = 0; c < 6; c++)
                        sum += longint'(ch[c]) * dubois_weight(k, c);
                    res[k] = saturate_channel(sum);
                end
                px.red   = res[0];
                px.green = res[1];
                px.blue  = res[2];
            end
            MODE_IL_LR, MODE_IL_RL:
            begin
                // Mode 3 swaps the dominant side, and odd rows take the other side.
                take_right = win_odd ^ (mode == MODE_IL_RL) ^ odd_row;
                px.red   = take_right ? p.right_red   : p.left_red;
                px.green = take_right ? p.right_green : p.left_green;
                px.blue  = take_right ? p.right_blue  : p.left_blue;
            end
            default:
            begin
                px.red   = '0;
                px.green = '0;
                px.blue  = '0;
            end
        endcase
        return px;
    endfunction

    task automatic report_mismatch(input string what, input pixel_t want, input pixel_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected r=%0d g=%0d b=%0d last=%0b, got r=%0d g=%0d b=%0d last=%0b",
                     $realtime, what, want.red, want.green, want.blue, want.last,
                     got.red, got.green, got.blue, got.last);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_q         = MODE_OPTIMIZED;
            win_odd_q      = 1'b0;
            width_q        = 13'd640;
            col_pos        = 0;
            row_odd        = 1'b0;
            owed_pixels.delete();
            mismatch_count = 0;
            pending_count  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (reg_index_t'(cfg_index))
                    REG_RENDER_MODE:  mode_q    = mode_t'(cfg_wdata[1:0]);
                    REG_WINDOW_Y_ODD: win_odd_q = cfg_wdata[0];
                    REG_LINE_WIDTH:   width_q   = cfg_wdata[LW_W-1:0];
                    default:          ;
                endcase
            end

            if (pixel_mon.valid && pixel_mon.ready)
            begin
                seen_px = {pixel_mon.out_red, pixel_mon.out_green,
                           pixel_mon.out_blue, pixel_mon.out_last};
                if (owed_pixels.size() == 0)
                    report_mismatch("pixel with no pair pending", '0, seen_px);
                else
                begin
                    owed_px = owed_pixels.pop_front();
                    if (seen_px.red !== owed_px.red || seen_px.green !== owed_px.green ||
                        seen_px.blue !== owed_px.blue || seen_px.last !== owed_px.last)
                        report_mismatch("pixel mismatch", owed_px, seen_px);
                end
            end

            if (pair_mon.valid && pair_mon.ready)
            begin
                pair_in = {pair_mon.left_red, pair_mon.left_green, pair_mon.left_blue,
                           pair_mon.right_red, pair_mon.right_green, pair_mon.right_blue,
                           pair_mon.frame_end};
                owed_pixels.push_back(predict_pixel(pair_in, mode_q, win_odd_q, row_odd));
                if (pair_in.frame_end)
                begin
                    col_pos = 0;
                    row_odd = 1'b0;
                end
                else if (col_pos + 1 >= row_length(width_q))
                begin
                    col_pos = 0;
                    row_odd = ~row_odd;
                end
                else
                    col_pos = col_pos + 1;
            end

            pending_count = owed_pixels.size();
        end
    end

endmodule

// File: bench/tb_stereo_pair_anaglyph_interlace_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stereo_pair_anaglyph_interlace_core
// Drives pixel pairs and register writes into the stereo combiner. A short
// directed run covers channel extremes, all four modes, row wrap and frame
// end; then random phases with random settings, random sender gaps, receiver
// stalls and one long output hold.
// ----------------------------------------------------------------------------
module tb_stereo_pair_anaglyph_interlace_core;
    import spai_pkg::*;

    localparam int IDLE_LIMIT     = 2000;
    localparam int HOLD_CYCLES    = 150;
    localparam int RANDOM_ITEMS   = 630;
    localparam int TAIL_CYCLES    = 40;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    int                   mismatches;
    int                   outstanding;
    int                   idle_cycles;
    bit                   send_steady;
    bit                   drain_steady;
    bit                   hold_request;

    spai_pair_if  pair_ch();
    spai_pixel_if pixel_ch();

    stereo_pair_anaglyph_interlace_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pair      (pair_ch),
        .pixel     (pixel_ch)
    );

    spai_pixel_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .pair_mon       (pair_ch),
        .pixel_mon      (pixel_ch),
        .mismatch_count (mismatches),
        .pending_count  (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Ends the run if neither channel completes a transaction for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (pair_ch.valid && pair_ch.ready) || (pixel_ch.valid && pixel_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Output side: a random stall before each pixel, or one long hold when asked.
    initial
    begin : pixel_drain
        int stall;
        pixel_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                stall        = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else
                stall = drain_steady ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                pixel_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pixel_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!pixel_ch.valid);
        end
    end

    function automatic pair_t make_pair(input int lr, input int lg, input int lb,
                                        input int rr, input int rg, input int rb,
                                        input bit last);
        pair_t p;
        p.left_red    = lr[7:0];
        p.left_green  = lg[7:0];
        p.left_blue   = lb[7:0];
        p.right_red   = rr[7:0];
        p.right_green = rg[7:0];
        p.right_blue  = rb[7:0];
        p.frame_end   = last;
        return p;
    endfunction

    // Channel levels lean toward the extremes so that clamping is exercised often.
    function automatic int channel_level();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 0;
        if (r == 1)
            return 255;
        return $urandom_range(0, 255);
    endfunction

    function automatic pair_t random_pair(input bit allow_end);
        return make_pair(channel_level(), channel_level(), channel_level(),
                         channel_level(), channel_level(), channel_level(),
                         allow_end && ($urandom_range(0, 19) == 0));
    endfunction

    function automatic int pick_width();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 0;
            1:       return 1;
            7:       return $urandom_range(17, 80);
            8:       return 640;
            9:       return ($urandom_range(0, 1) == 0) ? MAX_WIDTH
                                                        : $urandom_range(MAX_WIDTH + 1, 8191);
            default: return $urandom_range(2, 16);
        endcase
    endfunction

    task automatic send_pair(input pair_t p);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            pair_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pair_ch.left_red    <= p.left_red;
        pair_ch.left_green  <= p.left_green;
        pair_ch.left_blue   <= p.left_blue;
        pair_ch.right_red   <= p.right_red;
        pair_ch.right_green <= p.right_green;
        pair_ch.right_blue  <= p.right_blue;
        pair_ch.frame_end   <= p.frame_end;
        pair_ch.valid       <= 1'b1;
        do
            @(posedge clk);
        while (!pair_ch.ready);
    endtask

    // Stops offering pairs and waits until every owed pixel has come out.
    task automatic drain_all();
        pair_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Unused bits of the write data are random; the unused index is written too.
    task automatic configure(input mode_t mode, input bit win_odd, input int width);
        cfg_we    <= 1'b1;
        cfg_index <= REG_UNUSED;
        cfg_wdata <= CFG_W'($urandom());
        @(posedge clk);
        cfg_index <= REG_RENDER_MODE;
        cfg_wdata <= (CFG_W'($urandom()) & ~CFG_W'(3)) | CFG_W'(mode);
        @(posedge clk);
        cfg_index <= REG_WINDOW_Y_ODD;
        cfg_wdata <= (CFG_W'($urandom()) & ~CFG_W'(1)) | CFG_W'(win_odd);
        @(posedge clk);
        cfg_index <= REG_LINE_WIDTH;
        cfg_wdata <= CFG_W'(width);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : stimulus
        int sent;
        int count;
        int phase;
        rst_n               = 1'b0;
        send_steady         = 1'b0;
        drain_steady        = 1'b0;
        hold_request        = 1'b0;
        idle_cycles         = 0;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_RENDER_MODE;
        cfg_wdata          <= '0;
        pair_ch.valid      <= 1'b0;
        pair_ch.left_red   <= '0;
        pair_ch.left_green <= '0;
        pair_ch.left_blue  <= '0;
        pair_ch.right_red  <= '0;
        pair_ch.right_green <= '0;
        pair_ch.right_blue <= '0;
        pair_ch.frame_end  <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: optimized anaglyph at the channel extremes.
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 1'b0));
        send_pair(make_pair(255, 255, 255, 255, 255, 255, 1'b0));
        send_pair(make_pair(0, 255, 0, 85, 170, 85, 1'b0));
        send_pair(make_pair(170, 0, 255, 170, 85, 170, 1'b1));
        drain_all();

        // Dubois: saturation high on red and blue, negative sums giving zero.
        configure(MODE_DUBOIS, 1'b0, 640);
        send_pair(make_pair(255, 255, 255, 0, 0, 0, 1'b0));
        send_pair(make_pair(0, 0, 0, 255, 255, 255, 1'b0));
        send_pair(make_pair(255, 255, 255, 255, 255, 255, 1'b0));
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 1'b0));
        send_pair(make_pair(255, 0, 255, 0, 255, 0, 1'b1));
        drain_all();

        // Width zero acts as one, so every pixel toggles the row; frame end clears it.
        configure(MODE_IL_LR, 1'b0, 0);
        send_pair(make_pair(1, 2, 3, 4, 5, 6, 1'b0));
        send_pair(make_pair(7, 8, 9, 10, 11, 12, 1'b0));
        send_pair(make_pair(13, 14, 15, 16, 17, 18, 1'b1));
        send_pair(make_pair(19, 20, 21, 22, 23, 24, 1'b0));
        send_pair(make_pair(25, 26, 27, 28, 29, 30, 1'b0));
        drain_all();

        // Right side first with odd window parity; the frame ends in mid-row.
        configure(MODE_IL_RL, 1'b1, 3);
        send_pair(make_pair(31, 32, 33, 34, 35, 36, 1'b0));
        send_pair(make_pair(37, 38, 39, 40, 41, 42, 1'b1));
        send_pair(make_pair(43, 44, 45, 46, 47, 48, 1'b0));
        send_pair(make_pair(49, 50, 51, 52, 53, 54, 1'b0));
        send_pair(make_pair(55, 56, 57, 58, 59, 60, 1'b0));

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            drain_all();
            configure(mode_t'(2'($urandom_range(0, 3))), 1'($urandom_range(0, 1)),
                      pick_width());
            send_steady  = ($urandom_range(0, 3) == 0);
            drain_steady = ($urandom_range(0, 3) == 0);
            if (phase == 2)
            begin
                // The output is held off while pairs keep coming, so the input backs up.
                send_steady  = 1'b1;
                hold_request = 1'b1;
            end
            count = $urandom_range(15, 50);
            repeat (count)
            begin
                send_pair(random_pair(1'b1));
                sent++;
            end
            phase++;
        end

        drain_all();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
